FILE: hdl/dpd_pkg.sv
`timescale 1ns / 1ps

package dpd_pkg;

   localparam int PacketMaxDefault = 1024;
   localparam int QsLen = 10;

   localparam logic [7:0] CharStart    = 8'h24;  // '$'
   localparam logic [7:0] CharEnd      = 8'h23;  // '#'
   localparam logic [7:0] CharComma    = 8'h2C;
   localparam logic [7:0] CharColon    = 8'h3A;
   localparam logic [7:0] CharHalt     = 8'h3F;  // '?'
   localparam logic [7:0] CharRegRead  = 8'h67;  // 'g'
   localparam logic [7:0] CharRegWrite = 8'h47;  // 'G'
   localparam logic [7:0] CharMemRead  = 8'h6D;  // 'm'
   localparam logic [7:0] CharMemWrite = 8'h4D;  // 'M'
   localparam logic [7:0] CharThread   = 8'h48;  // 'H'
   localparam logic [7:0] CharDetach   = 8'h6B;  // 'k'

   localparam int CanonShift = 47;
   localparam logic [63-CanonShift:0] CanonHigh = 17'h1FFFF;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BODY,
      PH_SUM_HI,
      PH_SUM_LO
   } phase_type;

   typedef enum logic [1:0] {
      AP_ADDR,
      AP_LEN,
      AP_STOP,
      AP_DATA
   } arg_phase_type;

   typedef enum logic [2:0] {
      EV_IGNORE,
      EV_BODY,
      EV_ACK,
      EV_NAK,
      EV_OVERRUN,
      EV_BAD_DIGIT
   } event_type;

   typedef enum logic [3:0] {
      KIND_EMPTY,
      KIND_QSUPPORTED,
      KIND_HALT,
      KIND_REG_READ,
      KIND_REG_WRITE,
      KIND_MEM_READ,
      KIND_MEM_WRITE,
      KIND_THREAD,
      KIND_DETACH,
      KIND_OTHER
   } kind_type;

   typedef enum logic [1:0] {
      ARG_OK,
      ARG_MALFORMED,
      ARG_NONCANON
   } arg_error_type;

   // framer -> command decoder
   typedef struct packed {
      logic start;  // '$' seen while idle
      logic take;   // word stored as body byte
      logic ack;    // checksum matched
   } framer_ctl_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
   endfunction

   // valid only where is_hex holds; letters map through the low nibble
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) begin
         hex_value = c[3:0];
      end else begin
         hex_value = c[3:0] + 4'd9;
      end
   endfunction

   function automatic logic [7:0] qs_char(input logic [3:0] i);
      case (i)
         4'd0:    qs_char = 8'h71;  // q
         4'd1:    qs_char = 8'h53;  // S
         4'd2:    qs_char = 8'h75;  // u
         4'd3:    qs_char = 8'h70;  // p
         4'd4:    qs_char = 8'h70;  // p
         4'd5:    qs_char = 8'h6F;  // o
         4'd6:    qs_char = 8'h72;  // r
         4'd7:    qs_char = 8'h74;  // t
         4'd8:    qs_char = 8'h65;  // e
         4'd9:    qs_char = 8'h64;  // d
         default: qs_char = 8'h00;
      endcase
   endfunction

endpackage

FILE: hdl/debug_packet_deframer_decoder.sv
`timescale 1ns / 1ps
// A word that is accepted goes into the input register, then its result into the result register.
// Throughput: one word per cycle; the input register takes the next word
// while a result waits, and stalls only when both registers are full.
// Reset (synchronous, active high) returns the framer to idle and clears all counters.

module debug_packet_deframer_decoder import dpd_pkg::*; #(
   parameter int PACKET_MAX = PacketMaxDefault,
   localparam int CountWidth = $clog2(PACKET_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_event_res,
   output logic [7:0]            rsp_body_byte,
   output logic [3:0]            rsp_command_kind,
   output logic [1:0]            rsp_arg_error,
   output logic [63:0]           rsp_mem_address,
   output logic [63:0]           rsp_mem_length,
   output logic [CountWidth-1:0] rsp_payload_start,
   output logic [CountWidth-1:0] rsp_body_length,
   output logic [31:0]           rsp_received_count,
   output logic [31:0]           rsp_bad_checksum_count,
   output logic [31:0]           rsp_handled_count
);

   logic                  in_valid_ff;
   logic [7:0]            rx_byte_ff;
   logic                  out_valid_ff;
   logic                  step;

   framer_ctl_type        ctl;
   logic [CountWidth-1:0] body_count;
   event_type             event_res;
   logic [CountWidth-1:0] body_length;
   logic [31:0]           received_count;
   logic [31:0]           bad_checksum_count;
   logic [31:0]           handled_count;
   kind_type              command_kind;
   arg_error_type         arg_error;
   logic [63:0]           mem_address;
   logic [63:0]           mem_length;
   logic [CountWidth-1:0] payload_start;

   logic [2:0]            event_ff;
   logic [7:0]            body_byte_ff;
   logic [3:0]            kind_ff;
   logic [1:0]            arg_error_ff;
   logic [63:0]           address_ff;
   logic [63:0]           length_ff;
   logic [CountWidth-1:0] payload_start_ff;
   logic [CountWidth-1:0] body_length_ff;
   logic [31:0]           received_ff;
   logic [31:0]           bad_ff;
   logic [31:0]           handled_ff;

   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         rx_byte_ff <= req_rx_byte;
      end
   end

   dpd_framer #(
      .PACKET_MAX(PACKET_MAX)
   ) u_framer (
      .clock             (clock),
      .reset             (reset),
      .step              (step),
      .rx_byte           (rx_byte_ff),
      .ctl               (ctl),
      .body_count        (body_count),
      .event_res         (event_res),
      .body_length       (body_length),
      .received_count    (received_count),
      .bad_checksum_count(bad_checksum_count),
      .handled_count     (handled_count)
   );

   dpd_cmd_decode #(
      .PACKET_MAX(PACKET_MAX)
   ) u_cmd_decode (
      .clock        (clock),
      .reset        (reset),
      .step         (step && ctl != '0),
      .rx_byte      (rx_byte_ff),
      .ctl          (ctl),
      .body_count   (body_count),
      .command_kind (command_kind),
      .arg_error    (arg_error),
      .mem_address  (mem_address),
      .mem_length   (mem_length),
      .payload_start(payload_start)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         event_ff         <= event_res;
         body_byte_ff     <= (event_res == EV_BODY) ? rx_byte_ff : 8'h00;
         kind_ff          <= command_kind;
         arg_error_ff     <= arg_error;
         address_ff       <= mem_address;
         length_ff        <= mem_length;
         payload_start_ff <= payload_start;
         body_length_ff   <= body_length;
         received_ff      <= received_count;
         bad_ff           <= bad_checksum_count;
         handled_ff       <= handled_count;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_event_res          = event_ff;
   assign rsp_body_byte          = body_byte_ff;
   assign rsp_command_kind       = kind_ff;
   assign rsp_arg_error          = arg_error_ff;
   assign rsp_mem_address        = address_ff;
   assign rsp_mem_length         = length_ff;
   assign rsp_payload_start      = payload_start_ff;
   assign rsp_body_length        = body_length_ff;
   assign rsp_received_count     = received_ff;
   assign rsp_bad_checksum_count = bad_ff;
   assign rsp_handled_count      = handled_ff;

`ifndef SYNTHESIS
   a_body_byte_only_on_body: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && event_ff != EV_BODY |-> body_byte_ff == 8'h00)
      else $error("body byte set on a non-body word");

   a_decode_only_on_ack: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && event_ff != EV_ACK |->
         kind_ff == KIND_EMPTY && arg_error_ff == ARG_OK && address_ff == '0)
      else $error("command decode reported without an ack");

   a_args_clear_on_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && arg_error_ff != ARG_OK |->
         length_ff == '0 && payload_start_ff == '0)
      else $error("memory arguments reported with an argument error");

   a_input_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(rx_byte_ff))
      else $error("input register lost a word during a stall");
`endif

endmodule

FILE: hdl/dpd_framer.sv
`timescale 1ns / 1ps

module dpd_framer import dpd_pkg::*; #(
   parameter int PACKET_MAX = PacketMaxDefault,
   localparam int CountWidth = $clog2(PACKET_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   output framer_ctl_type        ctl,
   output logic [CountWidth-1:0] body_count,
   output event_type             event_res,
   output logic [CountWidth-1:0] body_length,
   output logic [31:0]           received_count,
   output logic [31:0]           bad_checksum_count,
   output logic [31:0]           handled_count
);

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [7:0]            sum_ff, sum_in;
   logic [3:0]            high_ff, high_in;
   logic [31:0]           good_ff, good_in;
   logic [31:0]           bad_ff, bad_in;
   logic [31:0]           done_ff, done_in;
   logic                  digit_ok;
   logic [3:0]            digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         sum_ff   <= '0;
         high_ff  <= '0;
         good_ff  <= '0;
         bad_ff   <= '0;
         done_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
         high_ff  <= high_in;
         good_ff  <= good_in;
         bad_ff   <= bad_in;
         done_ff  <= done_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      high_in     = high_ff;
      good_in     = good_ff;
      bad_in      = bad_ff;
      done_in     = done_ff;
      event_res   = EV_IGNORE;
      body_length = '0;
      ctl         = '0;
      digit_ok    = is_hex(rx_byte);
      digit       = hex_value(rx_byte);
      case (phase_ff)
         PH_IDLE: begin
            if (rx_byte == CharStart) begin
               ctl.start = 1'b1;
               phase_in  = PH_BODY;
               count_in  = '0;
               sum_in    = '0;
               high_in   = '0;
            end
         end
         PH_BODY: begin
            if (rx_byte == CharEnd) begin
               phase_in = PH_SUM_HI;
            end else if (count_ff < CountWidth'(PACKET_MAX)) begin
               ctl.take  = 1'b1;
               sum_in    = sum_ff + rx_byte;
               count_in  = count_ff + 1'b1;
               event_res = EV_BODY;
            end else begin
               event_res = EV_OVERRUN;
               phase_in  = PH_IDLE;
            end
         end
         PH_SUM_HI: begin
            if (digit_ok) begin
               high_in  = digit;
               phase_in = PH_SUM_LO;
            end else begin
               event_res = EV_BAD_DIGIT;
               phase_in  = PH_IDLE;
            end
         end
         PH_SUM_LO: begin
            phase_in = PH_IDLE;
            if (digit_ok) begin
               good_in     = good_ff + 1'b1;
               body_length = count_ff;
               if ({high_ff, digit} == sum_ff) begin
                  event_res = EV_ACK;
                  done_in   = done_ff + 1'b1;
                  ctl.ack   = 1'b1;
               end else begin
                  event_res = EV_NAK;
                  bad_in    = bad_ff + 1'b1;
               end
            end else begin
               event_res = EV_BAD_DIGIT;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   assign body_count         = count_ff;
   assign received_count     = good_in;
   assign bad_checksum_count = bad_in;
   assign handled_count      = done_in;

endmodule

FILE: hdl/dpd_cmd_decode.sv
`timescale 1ns / 1ps

module dpd_cmd_decode import dpd_pkg::*; #(
   parameter int PACKET_MAX = PacketMaxDefault,
   localparam int CountWidth = $clog2(PACKET_MAX + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [7:0]            rx_byte,
   input  framer_ctl_type        ctl,
   input  logic [CountWidth-1:0] body_count,
   output kind_type              command_kind,
   output arg_error_type         arg_error,
   output logic [63:0]           mem_address,
   output logic [63:0]           mem_length,
   output logic [CountWidth-1:0] payload_start
);

   localparam logic [63:0] ReadLimit = 64'((PACKET_MAX / 2) - 8);

   logic [7:0]            first_ff, first_in;
   logic                  prefix_ff, prefix_in;
   arg_phase_type         ap_ff, ap_in;
   logic [63:0]           addr_ff, addr_in;
   logic [63:0]           len_ff, len_in;
   logic                  fault_ff, fault_in;
   logic [CountWidth-1:0] start_ff, start_in;
   logic                  digit_ok;
   logic [3:0]            digit;
   logic                  is_wr;
   logic                  mem_bad;
   logic                  canon;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         prefix_ff <= 1'b1;
         ap_ff     <= AP_ADDR;
         addr_ff   <= '0;
         len_ff    <= '0;
         fault_ff  <= 1'b0;
         start_ff  <= '0;
      end else if (step) begin
         first_ff  <= first_in;
         prefix_ff <= prefix_in;
         ap_ff     <= ap_in;
         addr_ff   <= addr_in;
         len_ff    <= len_in;
         fault_ff  <= fault_in;
         start_ff  <= start_in;
      end
   end

   // argument parsing, one body word at a time
   always_comb begin
      first_in  = first_ff;
      prefix_in = prefix_ff;
      ap_in     = ap_ff;
      addr_in   = addr_ff;
      len_in    = len_ff;
      fault_in  = fault_ff;
      start_in  = start_ff;
      digit_ok  = is_hex(rx_byte);
      digit     = hex_value(rx_byte);
      is_wr     = (first_ff == CharMemWrite);
      if (ctl.start) begin
         first_in  = '0;
         prefix_in = 1'b1;
         ap_in     = AP_ADDR;
         addr_in   = '0;
         len_in    = '0;
         fault_in  = 1'b0;
         start_in  = '0;
      end else if (ctl.take) begin
         if (body_count == '0) begin
            first_in = rx_byte;
         end else if (first_ff == CharMemRead || is_wr) begin
            case (ap_ff)
               AP_ADDR: begin
                  if (rx_byte == CharComma) begin
                     ap_in = AP_LEN;
                  end else if (digit_ok) begin
                     addr_in = {addr_ff[59:0], digit};
                  end else begin
                     fault_in = 1'b1;
                     ap_in    = AP_STOP;
                  end
               end
               AP_LEN: begin
                  if (is_wr && rx_byte == CharColon) begin
                     ap_in    = AP_DATA;
                     start_in = body_count + 1'b1;
                  end else if (digit_ok) begin
                     len_in = {len_ff[59:0], digit};
                  end else begin
                     if (is_wr) begin
                        fault_in = 1'b1;
                     end
                     ap_in = AP_STOP;
                  end
               end
               default: ;
            endcase
         end
         if (body_count < CountWidth'(QsLen) && rx_byte != qs_char(body_count[3:0])) begin
            prefix_in = 1'b0;
         end
      end
   end

   // classification at the acked checksum
   always_comb begin
      command_kind  = KIND_EMPTY;
      arg_error     = ARG_OK;
      mem_address   = '0;
      mem_length    = '0;
      payload_start = '0;
      if (ctl.ack && body_count != '0) begin
         if (prefix_ff && body_count >= CountWidth'(QsLen)) begin
            command_kind = KIND_QSUPPORTED;
         end else begin
            case (first_ff)
               CharHalt:     command_kind = KIND_HALT;
               CharRegRead:  command_kind = KIND_REG_READ;
               CharRegWrite: command_kind = KIND_REG_WRITE;
               CharMemRead:  command_kind = KIND_MEM_READ;
               CharMemWrite: command_kind = KIND_MEM_WRITE;
               CharThread:   command_kind = KIND_THREAD;
               CharDetach:   command_kind = KIND_DETACH;
               default:      command_kind = KIND_OTHER;
            endcase
         end
      end
      mem_bad = fault_ff || ap_ff == AP_ADDR ||
                (command_kind == KIND_MEM_WRITE && ap_ff != AP_DATA);
      canon   = (addr_ff[63:CanonShift] == '0) || (addr_ff[63:CanonShift] == CanonHigh);
      if (command_kind == KIND_MEM_READ || command_kind == KIND_MEM_WRITE) begin
         if (mem_bad) begin
            arg_error = ARG_MALFORMED;
         end else if (!canon) begin
            arg_error = ARG_NONCANON;
         end else begin
            mem_address = addr_ff;
            if (command_kind == KIND_MEM_READ && len_ff > ReadLimit) begin
               mem_length = ReadLimit;
            end else begin
               mem_length = len_ff;
            end
            if (command_kind == KIND_MEM_WRITE) begin
               payload_start = start_ff;
            end
         end
      end
   end

endmodule

FILE: tb/tb_debug_packet_deframer_decoder.sv
`timescale 1ns / 1ps

module tb_debug_packet_deframer_decoder import dpd_pkg::*;;

   localparam int FrameMax = PacketMaxDefault;
   localparam int CountW = $clog2(FrameMax + 1);
   localparam logic [63:0] ReadClamp = 64'((FrameMax / 2) - 8);
   localparam logic [79:0] QsText = "qSupported";
   localparam int IdlePct = 6;
   localparam int LongHold = 300;
   localparam int CycleLimit = 200000;
   localparam int WordTarget = 1850;
   localparam int NumDirected = 28;

   // checksum handling of a generated frame
   localparam int FateGood = 0;
   localparam int FateWrongSum = 1;
   localparam int FateBadHigh = 2;
   localparam int FateBadLow = 3;

   typedef struct packed {
      event_type       ev;
      logic [7:0]      body;
      kind_type        kind;
      arg_error_type   aerr;
      logic [63:0]     addr;
      logic [63:0]     len;
      logic [CountW-1:0] pstart;
      logic [CountW-1:0] blen;
      logic [31:0]     rcv;
      logic [31:0]     bad;
      logic [31:0]     hnd;
   } result_type;

   typedef struct {
      logic [7:0]    b;
      bit            fixed;
      event_type     ev;
      kind_type      kind;
      arg_error_type aerr;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_event_res;
   logic [7:0] rsp_body_byte;
   logic [3:0] rsp_command_kind;
   logic [1:0] rsp_arg_error;
   logic [63:0] rsp_mem_address;
   logic [63:0] rsp_mem_length;
   logic [CountW-1:0] rsp_payload_start;
   logic [CountW-1:0] rsp_body_length;
   logic [31:0] rsp_received_count;
   logic [31:0] rsp_bad_checksum_count;
   logic [31:0] rsp_handled_count;

   debug_packet_deframer_decoder #(.PACKET_MAX(FrameMax)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_event_res(rsp_event_res),
      .rsp_body_byte(rsp_body_byte),
      .rsp_command_kind(rsp_command_kind),
      .rsp_arg_error(rsp_arg_error),
      .rsp_mem_address(rsp_mem_address),
      .rsp_mem_length(rsp_mem_length),
      .rsp_payload_start(rsp_payload_start),
      .rsp_body_length(rsp_body_length),
      .rsp_received_count(rsp_received_count),
      .rsp_bad_checksum_count(rsp_bad_checksum_count),
      .rsp_handled_count(rsp_handled_count)
   );

   always #4 clock = ~clock;

   // decoder state mirror
   phase_type     link_phase = PH_IDLE;
   int            body_len;
   logic [7:0]    sum_acc;
   logic [3:0]    sum_hi_nib;
   logic [7:0]    cmd_byte;
   bit            qs_match;
   arg_phase_type arg_stage;
   logic [63:0]   addr_acc;
   logic [63:0]   len_acc;
   bit            arg_bad;
   int            data_idx;
   logic [31:0]   rx_total = '0;
   logic [31:0]   nak_total = '0;
   logic [31:0]   ack_total = '0;

   result_type predicted_results[$];
   int mismatches = 0;
   int words_sent = 0;
   int event_tally [8];
   int hold_requests = 0;
   bit quiet_stretch = 1'b0;

   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
      if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 10)};
      if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 10)};
      return 5'b0;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return 8'(8'h30 + n);
      return 8'((($urandom_range(1) != 0) ? 8'h41 : 8'h61) + n - 10);
   endfunction

   // any byte that does not end the body
   function automatic logic [7:0] random_body_byte();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CharEnd);
      return c;
   endfunction

   // non-hex byte that does not end the body or split the arguments
   function automatic logic [7:0] random_junk();
      logic [7:0] c;
      do c = 8'($urandom);
      while (nibble_of(c) != 5'b0 || c == CharEnd || c == CharComma || c == CharColon);
      return c;
   endfunction

   task automatic clear_packet();
      body_len = 0;
      sum_acc = '0;
      sum_hi_nib = '0;
      cmd_byte = '0;
      qs_match = 1'b1;
      arg_stage = AP_ADDR;
      addr_acc = '0;
      len_acc = '0;
      arg_bad = 1'b0;
      data_idx = 0;
   endtask

   task automatic decode_byte(input logic [7:0] b, output result_type r);
      logic [4:0] hx;
      logic [16:0] top;
      int idx;
      hx = nibble_of(b);
      r = '0;
      case (link_phase)
         PH_IDLE: begin
            if (b == CharStart) begin
               clear_packet();
               link_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            if (b == CharEnd) begin
               link_phase = PH_SUM_HI;
            end else if (body_len < FrameMax) begin
               idx = body_len;
               if (idx == 0) begin
                  cmd_byte = b;
               end else if (cmd_byte == CharMemRead || cmd_byte == CharMemWrite) begin
                  if (arg_stage == AP_ADDR) begin
                     if (b == CharComma) arg_stage = AP_LEN;
                     else if (hx[4]) addr_acc = {addr_acc[59:0], hx[3:0]};
                     else begin
                        arg_bad = 1'b1;
                        arg_stage = AP_STOP;
                     end
                  end else if (arg_stage == AP_LEN) begin
                     if (cmd_byte == CharMemWrite && b == CharColon) begin
                        arg_stage = AP_DATA;
                        data_idx = idx + 1;
                     end else if (hx[4]) begin
                        len_acc = {len_acc[59:0], hx[3:0]};
                     end else begin
                        // m just stops at the first non-hex byte
                        if (cmd_byte == CharMemWrite) arg_bad = 1'b1;
                        arg_stage = AP_STOP;
                     end
                  end
               end
               if (idx < QsLen && b != QsText[79 - 8*idx -: 8]) qs_match = 1'b0;
               sum_acc = sum_acc + b;
               body_len = idx + 1;
               r.ev = EV_BODY;
               r.body = b;
            end else begin
               r.ev = EV_OVERRUN;
               link_phase = PH_IDLE;
            end
         end
         PH_SUM_HI: begin
            if (hx[4]) begin
               sum_hi_nib = hx[3:0];
               link_phase = PH_SUM_LO;
            end else begin
               r.ev = EV_BAD_DIGIT;
               link_phase = PH_IDLE;
            end
         end
         default: begin
            if (hx[4]) begin
               rx_total++;
               r.blen = CountW'(body_len);
               if ({sum_hi_nib, hx[3:0]} == sum_acc) begin
                  r.ev = EV_ACK;
                  ack_total++;
                  if (body_len == 0) r.kind = KIND_EMPTY;
                  else if (qs_match && body_len >= QsLen) r.kind = KIND_QSUPPORTED;
                  else begin
                     case (cmd_byte)
                        CharHalt:     r.kind = KIND_HALT;
                        CharRegRead:  r.kind = KIND_REG_READ;
                        CharRegWrite: r.kind = KIND_REG_WRITE;
                        CharMemRead:  r.kind = KIND_MEM_READ;
                        CharMemWrite: r.kind = KIND_MEM_WRITE;
                        CharThread:   r.kind = KIND_THREAD;
                        CharDetach:   r.kind = KIND_DETACH;
                        default:      r.kind = KIND_OTHER;
                     endcase
                  end
                  if (r.kind == KIND_MEM_READ || r.kind == KIND_MEM_WRITE) begin
                     top = addr_acc[63:CanonShift];
                     if (arg_bad || arg_stage == AP_ADDR ||
                         (r.kind == KIND_MEM_WRITE && arg_stage != AP_DATA)) begin
                        r.aerr = ARG_MALFORMED;
                     end else if (top != '0 && top != CanonHigh) begin
                        r.aerr = ARG_NONCANON;
                     end else begin
                        r.addr = addr_acc;
                        r.len = len_acc;
                        if (r.kind == KIND_MEM_READ && len_acc > ReadClamp) r.len = ReadClamp;
                        if (r.kind == KIND_MEM_WRITE) r.pstart = CountW'(data_idx);
                     end
                  end
               end else begin
                  r.ev = EV_NAK;
                  nak_total++;
               end
            end else begin
               r.ev = EV_BAD_DIGIT;
            end
            link_phase = PH_IDLE;
         end
      endcase
      r.rcv = rx_total;
      r.bad = nak_total;
      r.hnd = ack_total;
   endtask

   task automatic send_word(input stim_row_type row);
      result_type r;
      while (!quiet_stretch && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= row.b;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_byte(row.b, r);
      if (row.fixed) begin
         r.ev = row.ev;
         r.kind = row.kind;
         r.aerr = row.aerr;
      end
      predicted_results.push_back(r);
      event_tally[r.ev]++;
      words_sent++;
   endtask

   task automatic send_plain(input logic [7:0] b);
      stim_row_type row;
      row.b = b;
      row.fixed = 1'b0;
      row.ev = EV_IGNORE;
      row.kind = KIND_EMPTY;
      row.aerr = ARG_OK;
      send_word(row);
   endtask

   task automatic push_hex(ref logic [7:0] body[$], input logic [63:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) begin
         body.push_back(hex_char(i < 16 ? v[4*i +: 4] : 4'($urandom)));
      end
   endtask

   task automatic send_packet(input logic [7:0] body[$], input int fate);
      logic [7:0] csum;
      csum = '0;
      foreach (body[i]) csum = csum + body[i];
      if (fate == FateWrongSum) csum = csum + 8'($urandom_range(255, 1));
      send_plain(CharStart);
      foreach (body[i]) send_plain(body[i]);
      send_plain(CharEnd);
      send_plain(fate == FateBadHigh ? random_junk() : hex_char(csum[7:4]));
      if (fate != FateBadHigh) send_plain(fate == FateBadLow ? random_junk() : hex_char(csum[3:0]));
   endtask

   // valid goes low at once, then the sender sits until the block is empty
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (predicted_results.size() != 0);
   endtask

   // receiver: random stalls, one long hold-off on request
   int hold_left = 0;
   int holds_granted = 0;
   always @(posedge clock) begin
      if (holds_granted != hold_requests) begin
         holds_granted = hold_requests;
         hold_left = LongHold;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet_stretch || ($urandom_range(99) >= IdlePct);
      end
   end

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (predicted_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result word, expected none, actual event %0d",
                     $time, rsp_event_res);
         end else begin
            want = predicted_results.pop_front();
            check_field("event_res", want.ev, rsp_event_res);
            check_field("body_byte", want.body, rsp_body_byte);
            check_field("command_kind", want.kind, rsp_command_kind);
            check_field("arg_error", want.aerr, rsp_arg_error);
            check_field("mem_address", want.addr, rsp_mem_address);
            check_field("mem_length", want.len, rsp_mem_length);
            check_field("payload_start", want.pstart, rsp_payload_start);
            check_field("body_length", want.blen, rsp_body_length);
            check_field("received_count", want.rcv, rsp_received_count);
            check_field("bad_checksum_count", want.bad, rsp_bad_checksum_count);
            check_field("handled_count", want.hnd, rsp_handled_count);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < CycleLimit; cycles++) @(posedge clock);
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, predicted_results.size());
      $display("** debug_packet_deframer_decoder: FAILED **");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows [NumDirected];
      logic [7:0] body[$];
      logic [7:0] nb;
      logic [63:0] v;
      int pkt;
      int pick;
      int flaw;
      int n;
      int j;
      int fate;
      bit wr;

      // fixed rows carry the obvious answer; the rest go to the predictor
      directed_rows = '{
         '{8'h00,        1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{8'hFF,        1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharStart,    1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharEnd,      1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"0",          1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"0",          1'b1, EV_ACK,       KIND_EMPTY,    ARG_OK},
         '{CharStart,    1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharHalt,     1'b1, EV_BODY,      KIND_EMPTY,    ARG_OK},
         '{CharEnd,      1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"3",          1'b1, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"f",          1'b1, EV_ACK,       KIND_HALT,     ARG_OK},
         '{CharStart,    1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharRegRead,  1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharEnd,      1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"0",          1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"0",          1'b1, EV_NAK,       KIND_EMPTY,    ARG_OK},
         '{CharStart,    1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharDetach,   1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharEnd,      1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"z",          1'b1, EV_BAD_DIGIT, KIND_EMPTY,    ARG_OK},
         '{CharStart,    1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharMemRead,  1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"1",          1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharComma,    1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"2",          1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{CharEnd,      1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"F",          1'b0, EV_IGNORE,    KIND_EMPTY,    ARG_OK},
         '{"C",          1'b1, EV_ACK,       KIND_MEM_READ, ARG_OK}
      };
      foreach (event_tally[i]) event_tally[i] = 0;
      clear_packet();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_word(directed_rows[i]);

      pkt = 0;
      while (pkt < 45 || words_sent < WordTarget) begin
         pkt++;
         if (pkt == 5) hold_requests++;
         if (pkt == 15) wait_for_results();
         quiet_stretch = (pkt >= 25 && pkt < 40);

         if (pkt == 20) begin
            // fill the body to the limit, then one more byte aborts it
            send_plain(CharStart);
            repeat (FrameMax + 1) send_plain(random_body_byte());
         end

         // line noise between frames
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(3, 1)) begin
               do nb = 8'($urandom); while (nb == CharStart);
               send_plain(nb);
            end
         end

         body.delete();
         pick = $urandom_range(99);
         if (pick < 5) begin
            // empty body
         end else if (pick < 13) begin
            for (int i = 0; i < QsLen; i++) body.push_back(QsText[79 - 8*i -: 8]);
            n = $urandom_range(3);
            if (n == 0) begin
               repeat ($urandom_range(QsLen - 1, 1)) void'(body.pop_back());
            end else if (n == 1) begin
               j = $urandom_range(QsLen - 1);
               body[j] = body[j] ^ 8'h20;
            end else begin
               repeat ($urandom_range(12)) body.push_back(random_body_byte());
            end
         end else if (pick < 26) begin
            body.push_back(pick < 18 ? CharHalt : (pick < 22 ? CharRegRead : CharDetach));
            if ($urandom_range(3) == 0)
               repeat ($urandom_range(4, 1)) body.push_back(random_body_byte());
         end else if (pick < 32) begin
            body.push_back(CharRegWrite);
            push_hex(body, {$urandom, $urandom}, $urandom_range(16));
         end else if (pick < 76) begin
            wr = (pick >= 56);
            body.push_back(wr ? CharMemWrite : CharMemRead);
            flaw = $urandom_range(9);
            case ($urandom_range(3))
               0: begin
                  v = 64'($urandom);
                  n = $urandom_range(8, 1);
               end
               1: begin
                  v = {CanonHigh, 47'({$urandom, $urandom})};
                  n = 16;
               end
               2: begin
                  v = {$urandom, $urandom};
                  n = 16;
               end
               default: begin
                  v = ($urandom_range(1) != 0) ? '1 : '0;
                  n = 16 + $urandom_range(1);
               end
            endcase
            if ($urandom_range(19) == 0) n = 0;
            push_hex(body, v, n);
            if (flaw == 0) body.push_back(random_junk());
            if (flaw != 1) begin
               body.push_back(CharComma);
               v = ($urandom_range(1) != 0) ? 64'($urandom_range(1023)) : {$urandom, $urandom};
               push_hex(body, v, ($urandom_range(3) == 0) ? 17 : $urandom_range(4, 1));
               if (wr && flaw != 2) begin
                  body.push_back(CharColon);
                  repeat ($urandom_range(8)) body.push_back(hex_char(4'($urandom)));
               end else if (!wr && flaw == 2) begin
                  // trailing bytes after an m length are ignored
                  repeat ($urandom_range(4, 1)) body.push_back(random_body_byte());
               end
            end
         end else if (pick < 83) begin
            body.push_back(CharThread);
            body.push_back(($urandom_range(1) != 0) ? "g" : "c");
            push_hex(body, {$urandom, $urandom}, $urandom_range(4, 1));
         end else begin
            repeat ($urandom_range(21, 1)) body.push_back(random_body_byte());
         end

         fate = $urandom_range(99);
         send_packet(body, (fate < 80) ? FateGood : (fate < 90) ? FateWrongSum :
                           (fate < 95) ? FateBadHigh : FateBadLow);
      end
      quiet_stretch = 1'b0;

      wait_for_results();
      repeat (10) @(posedge clock);

      $display("Sent %0d words in %0d random frames after %0d directed words.",
               words_sent, pkt, NumDirected);
      $display("Results: %0d acks, %0d naks, %0d checksum-digit aborts, %0d overruns.",
               event_tally[EV_ACK], event_tally[EV_NAK], event_tally[EV_BAD_DIGIT],
               event_tally[EV_OVERRUN]);
      if (mismatches == 0) begin
         $display("** debug_packet_deframer_decoder: PASSED **");
      end else begin
         $display("** debug_packet_deframer_decoder: FAILED **");
      end
      $finish;
   end

endmodule
